// ----- sv/imrt_pkg.sv -----
// Shared constants, codes and control types of the I2C mux routing table.
`default_nettype none

package imrt_pkg;

   // Table geometry.
   localparam int CHANNEL_COUNT     = 8;
   localparam int SLOTS_PER_CHANNEL = 4;
   localparam int TABLE_DEPTH       = CHANNEL_COUNT * SLOTS_PER_CHANNEL;
   localparam int IDX_W             = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SLOT_W            = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;

   // Field widths fixed by the interface.
   localparam int CH_W        = 3;
   localparam int REQ_CH_W    = 4;
   localparam int DEV_ADDR_W  = 7;
   localparam int CMD_W       = 2;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   // Reset address of the multiplexer chip.
   localparam logic [DEV_ADDR_W-1:0] MUX_ADDR_RESET = 7'd112;

   // Command codes carried in the request sideband.
   typedef enum logic [CMD_W-1:0] {
      OP_ADD    = 2'd0,
      OP_ACCESS = 2'd1,
      OP_SELECT = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Outcome of one item, held until the response register takes it.
   typedef enum logic [1:0] {
      RES_FAIL  = 2'd0,
      RES_ADD   = 2'd1,
      RES_ROUTE = 2'd2
   } res_kind_type;

   // Where the resolved channel comes from.
   typedef enum logic {
      SEL_REQ  = 1'b0,
      SEL_SCAN = 1'b1
   } found_sel_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_DECODE   = 3'd1,
      ST_ADD      = 3'd2,
      ST_ACC      = 3'd3,
      ST_ACC_TAIL = 3'd4,
      ST_RESULT   = 3'd5
   } ctl_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic          load_req;
      logic          acc_step;
      logic          add_step;
      logic          add_write;
      logic          latch;
      res_kind_type  kind;
      found_sel_type sel;
      logic          out_load;
   } ctl_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      op_type op;
      logic   ch_ok;
      logic   slot_last;
      logic   scan_last;
      logic   hit;
      logic   free;
      logic   out_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

// ----- sv/imrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module imrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- sv/imrt_ctrl.sv -----
// Controller state machine that sequences add, lookup and select items.
`default_nettype none

module imrt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire imrt_pkg::ctl_sts_type sts,
   output imrt_pkg::ctl_cmd_type     cmd
);

   imrt_pkg::ctl_state_type state_ff;
   imrt_pkg::ctl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imrt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.kind   = imrt_pkg::RES_FAIL;
      cmd.sel    = imrt_pkg::SEL_REQ;
      unique case (state_ff)
         imrt_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
            if (req_tvalid) begin
               state_in = imrt_pkg::ST_DECODE;
            end
         end
         imrt_pkg::ST_DECODE: begin
            unique case (sts.op)
               imrt_pkg::OP_ADD: begin
                  if (sts.ch_ok) begin
                     state_in = imrt_pkg::ST_ADD;
                  end else begin
                     cmd.latch = 1'b1;
                     state_in  = imrt_pkg::ST_RESULT;
                  end
               end
               imrt_pkg::OP_ACCESS: begin
                  state_in = imrt_pkg::ST_ACC;
               end
               imrt_pkg::OP_SELECT: begin
                  cmd.latch = 1'b1;
                  if (sts.ch_ok) begin
                     cmd.kind = imrt_pkg::RES_ROUTE;
                  end
                  state_in = imrt_pkg::ST_RESULT;
               end
               default: begin
                  cmd.latch = 1'b1;
                  state_in  = imrt_pkg::ST_RESULT;
               end
            endcase
         end
         imrt_pkg::ST_ADD: begin
            // Walk the slots of the requested channel until a free one shows up.
            if (sts.free) begin
               cmd.add_write = 1'b1;
               cmd.latch     = 1'b1;
               cmd.kind      = imrt_pkg::RES_ADD;
               state_in      = imrt_pkg::ST_RESULT;
            end else if (sts.slot_last) begin
               cmd.latch = 1'b1;
               state_in  = imrt_pkg::ST_RESULT;
            end else begin
               cmd.add_step = 1'b1;
            end
         end
         imrt_pkg::ST_ACC: begin
            // One table read issued per cycle; the compare follows in the next cycle.
            if (sts.hit) begin
               cmd.latch = 1'b1;
               cmd.kind  = imrt_pkg::RES_ROUTE;
               cmd.sel   = imrt_pkg::SEL_SCAN;
               state_in  = imrt_pkg::ST_RESULT;
            end else begin
               cmd.acc_step = 1'b1;
               if (sts.scan_last) begin
                  state_in = imrt_pkg::ST_ACC_TAIL;
               end
            end
         end
         imrt_pkg::ST_ACC_TAIL: begin
            // Compare for the last entry read.
            cmd.latch = 1'b1;
            cmd.sel   = imrt_pkg::SEL_SCAN;
            if (sts.hit) begin
               cmd.kind = imrt_pkg::RES_ROUTE;
            end
            state_in = imrt_pkg::ST_RESULT;
         end
         imrt_pkg::ST_RESULT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = imrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imrt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/imrt_dpath.sv -----
// Datapath: request registers, routing table, scan counters and response register.
`default_nettype none

module imrt_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [imrt_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire logic [imrt_pkg::CMD_W-1:0]            req_tuser,
   input  wire logic                                  csr_wr_en,
   input  wire logic [imrt_pkg::DEV_ADDR_W-1:0]       csr_wr_data,
   input  wire imrt_pkg::ctl_cmd_type                 cmd,
   output imrt_pkg::ctl_sts_type                      sts,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [imrt_pkg::RSP_TDATA_W-1:0]           rsp_tdata
);

   localparam int IDX_W  = imrt_pkg::IDX_W;
   localparam int SLOT_W = imrt_pkg::SLOT_W;
   localparam int CH_W   = imrt_pkg::CH_W;
   localparam int AW     = imrt_pkg::DEV_ADDR_W;

   localparam logic [AW-1:0] MUX_ADDR_RESET_W = imrt_pkg::MUX_ADDR_RESET;

   // Captured request.
   imrt_pkg::op_type              op_ff;
   logic [AW-1:0]                 dev_addr_ff;
   logic [imrt_pkg::REQ_CH_W-1:0] req_ch_ff;

   // Scan counters and the read in flight.
   logic [CH_W-1:0]   ch_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              rd_pend_ff;
   logic [CH_W-1:0]   rd_ch_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   // Per-entry valid bits; an entry that is not valid is an empty slot.
   logic [imrt_pkg::TABLE_DEPTH-1:0] vld_ff;

   // Outcome and routing state.
   imrt_pkg::res_kind_type kind_ff;
   logic [CH_W-1:0]        found_ff;
   logic [CH_W-1:0]        active_ch_ff;
   logic                   active_vld_ff;
   logic [AW-1:0]          mux_addr_ff;

   // Response register.
   logic                             rsp_tvalid_ff;
   logic [imrt_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic [IDX_W-1:0] acc_idx;
   logic [IDX_W-1:0] add_idx;
   logic [AW-1:0]    rd_data;
   logic             slot_last;
   logic             ch_last;
   logic             mux_write;
   logic [7:0]       addr_byte;
   logic [7:0]       sel_byte;

   // Table indexes for the lookup walk and for the add walk.
   assign acc_idx = IDX_W'(ch_ff) * IDX_W'(imrt_pkg::SLOTS_PER_CHANNEL) + IDX_W'(slot_ff);
   assign add_idx = IDX_W'(req_ch_ff[CH_W-1:0]) * IDX_W'(imrt_pkg::SLOTS_PER_CHANNEL)
                    + IDX_W'(slot_ff);

   assign slot_last = (slot_ff == SLOT_W'(imrt_pkg::SLOTS_PER_CHANNEL - 1));
   assign ch_last   = (ch_ff == CH_W'(imrt_pkg::CHANNEL_COUNT - 1));

   // Address store: written by add, read once per cycle by lookup.
   imrt_ram #(
      .WIDTH (AW),
      .DEPTH (imrt_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.add_write),
      .wr_addr (add_idx),
      .wr_data (dev_addr_ff),
      .rd_addr (acc_idx),
      .rd_data (rd_data)
   );

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff       <= imrt_pkg::op_type'(req_tuser);
         dev_addr_ff <= req_tdata[AW-1:0];
         req_ch_ff   <= req_tdata[AW +: imrt_pkg::REQ_CH_W];
      end
   end

   // Scan counters and read tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff      <= '0;
         slot_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else if (cmd.load_req) begin
         ch_ff      <= '0;
         slot_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else if (cmd.acc_step) begin
         rd_pend_ff <= 1'b1;
         if (slot_last) begin
            slot_ff <= '0;
            ch_ff   <= ch_last ? '0 : ch_ff + CH_W'(1);
         end else begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
      end else if (cmd.add_step) begin
         slot_ff <= slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_step) begin
         rd_ch_ff  <= ch_ff;
         rd_idx_ff <= acc_idx;
      end
   end

   // Valid bits: reset empties the whole table at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.add_write) begin
         vld_ff[add_idx] <= 1'b1;
      end
   end

   // Outcome latch.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= cmd.kind;
         if (cmd.kind == imrt_pkg::RES_FAIL) begin
            found_ff <= '0;
         end else if (cmd.sel == imrt_pkg::SEL_SCAN) begin
            found_ff <= rd_ch_ff;
         end else begin
            found_ff <= req_ch_ff[CH_W-1:0];
         end
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mux_addr_ff <= MUX_ADDR_RESET_W;
      end else if (csr_wr_en) begin
         mux_addr_ff <= csr_wr_data;
      end
   end

   // A mux write is due when a route lands on a channel other than the active one.
   assign mux_write = (kind_ff == imrt_pkg::RES_ROUTE)
                      && (!active_vld_ff || (active_ch_ff != found_ff));
   assign addr_byte = mux_write ? {mux_addr_ff, 1'b0} : 8'd0;
   assign sel_byte  = mux_write ? (8'd1 << found_ff) : 8'd0;

   // Active channel tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ch_ff  <= '0;
         active_vld_ff <= 1'b0;
      end else if (cmd.out_load && mux_write) begin
         active_ch_ff  <= found_ff;
         active_vld_ff <= 1'b1;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata_ff <= {3'd0, sel_byte, addr_byte, mux_write, found_ff,
                          (kind_ff == imrt_pkg::RES_FAIL)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Status to the controller.
   always_comb begin
      sts           = '0;
      sts.op        = op_ff;
      sts.ch_ok     = (req_ch_ff < imrt_pkg::REQ_CH_W'(imrt_pkg::CHANNEL_COUNT));
      sts.slot_last = slot_last;
      sts.scan_last = slot_last && ch_last;
      sts.hit       = rd_pend_ff && vld_ff[rd_idx_ff] && (rd_data == dev_addr_ff);
      sts.free      = !vld_ff[add_idx];
      sts.out_free  = !rsp_tvalid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

// ----- sv/i2c_mux_route_table_top.sv -----
// Top level of the I2C mux routing table.
//
//   channel  | direction | ports                         | contents
//   request  | in        | req_tvalid/tready/tdata/tuser | command, device address, channel
//   response | out       | rsp_tvalid/tready/tdata       | status, channel, mux write bytes
//   config   | in        | csr_wr_en/csr_wr_data         | mux chip address
//
// An add walks the slots of its channel until one is free; a select or a rejected item goes
// straight to the result state; a lookup walks the table until a hit or its last entry:
// the lookup reads one table entry per cycle through the single read port of the table RAM.
// One item is worked at a time; the next is accepted once the result sits in the
// response register. Synchronous reset empties the table at once (valid bits).
// A stalled response holds the block in its result state until the register frees up.
`default_nettype none

module i2c_mux_route_table_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [6:0] device_address, [10:7] channel, [15:11] zero
   input  wire logic [imrt_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // [1:0] cmd
   input  wire logic [imrt_pkg::CMD_W-1:0]            req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [0] status, [3:1] found_channel, [4] mux_write, [12:5] mux_address_byte,
   // [20:13] select_byte, [23:21] zero
   output logic [imrt_pkg::RSP_TDATA_W-1:0]           rsp_tdata,
   input  wire logic                                  csr_wr_en,
   input  wire logic [imrt_pkg::DEV_ADDR_W-1:0]       csr_wr_data
);

   imrt_pkg::ctl_cmd_type cmd;
   imrt_pkg::ctl_sts_type sts;

   // Sequencer.
   imrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Table and result logic.
   imrt_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- sv/imrt_checker.sv -----
// Port-level checks of the I2C mux routing table, bound to the top level.
`default_nettype none

module imrt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [imrt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // No response is pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Only one item is in work: the input is closed in the cycle after a request is accepted.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in work");

   // A mux write is a successful route with a one-hot select and a write-direction address.
   a_mux_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> !rsp_tdata[0] && !rsp_tdata[5]
                                     && $onehot(rsp_tdata[20:13]))
      else $error("malformed mux write");

   // A failure carries no channel and no mux write.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> (rsp_tdata[20:1] == 20'd0))
      else $error("failed item carries data");

endmodule

bind i2c_mux_route_table_top imrt_checker u_imrt_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the I2C mux routing table: a directed table, then random traffic.
`timescale 1ns / 100ps

module tb;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          PHASE_ITEMS = 250;
   localparam logic [7:0]  EMPTY_SLOT  = 8'h80;

   // Expected response fields, status in the top bit down to the select byte.
   typedef struct packed {
      logic       status;
      logic [2:0] found;
      logic       mux_write;
      logic [7:0] addr_byte;
      logic [7:0] sel_byte;
   } mux_route_type;

   // One row of the directed table.
   typedef struct packed {
      imrt_pkg::op_type op;
      logic [6:0]       addr;
      logic [3:0]       ch;
      logic             typed;
      mux_route_type    res;
   } stim_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   // [6:0] device_address, [10:7] channel, [15:11] zero
   logic [imrt_pkg::REQ_TDATA_W-1:0]     req_tdata;
   // [1:0] cmd
   logic [imrt_pkg::CMD_W-1:0]           req_tuser;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // [0] status, [3:1] found_channel, [4] mux_write, [12:5] mux_address_byte,
   // [20:13] select_byte, [23:21] zero
   logic [imrt_pkg::RSP_TDATA_W-1:0]     rsp_tdata;
   logic                                 csr_wr_en;
   logic [imrt_pkg::DEV_ADDR_W-1:0]      csr_wr_data;

   // Predictor state.
   logic [7:0]                 route_slots [0:imrt_pkg::TABLE_DEPTH-1];
   logic [2:0]                 cur_channel;
   logic                       cur_valid;
   logic [6:0]                 chip_addr;

   mux_route_type              pending_routes [$];
   stim_row_type               rows [$];
   int                         error_count = 0;
   int                         checked_count = 0;
   int                         write_count = 0;
   int                         op_hist [4];
   int                         req_idle_pct = 12;
   int                         rsp_idle_pct = 67;
   int                         stall_requests = 0;
   int                         cycle_count = 0;

   i2c_mux_route_table_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Works out the response to one request and updates the table and active channel.
   function automatic mux_route_type predict_route(imrt_pkg::op_type op, logic [6:0] addr,
                                                   logic [3:0] ch);
      mux_route_type r;
      logic          resolved;
      logic          placed;
      logic [2:0]    target;
      int            base;
      int            c;
      int            s;
      r        = '0;
      r.status = 1'b1;
      resolved = 1'b0;
      placed   = 1'b0;
      target   = '0;
      base     = int'(ch) * imrt_pkg::SLOTS_PER_CHANNEL;
      case (op)
         imrt_pkg::OP_ADD: begin
            if (ch < imrt_pkg::CHANNEL_COUNT) begin
               for (s = 0; s < imrt_pkg::SLOTS_PER_CHANNEL; s++) begin
                  if (!placed && route_slots[base + s] == EMPTY_SLOT) begin
                     route_slots[base + s] = {1'b0, addr};
                     placed = 1'b1;
                  end
               end
            end
            if (placed) begin
               r.status = 1'b0;
               r.found  = ch[2:0];
            end
         end
         imrt_pkg::OP_ACCESS: begin
            // Channels in order, slots within each: the lowest channel wins.
            for (c = 0; c < imrt_pkg::CHANNEL_COUNT; c++) begin
               for (s = 0; s < imrt_pkg::SLOTS_PER_CHANNEL; s++) begin
                  if (!resolved && route_slots[c * imrt_pkg::SLOTS_PER_CHANNEL + s]
                                   == {1'b0, addr}) begin
                     resolved = 1'b1;
                     target   = c[2:0];
                  end
               end
            end
         end
         imrt_pkg::OP_SELECT: begin
            if (ch < imrt_pkg::CHANNEL_COUNT) begin
               resolved = 1'b1;
               target   = ch[2:0];
            end
         end
         default: begin
         end
      endcase
      if (resolved) begin
         r.status = 1'b0;
         r.found  = target;
         if (!cur_valid || cur_channel != target) begin
            r.mux_write = 1'b1;
            r.addr_byte = {chip_addr, 1'b0};
            r.sel_byte  = 8'h01 << target;
            cur_channel = target;
            cur_valid   = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic add_row(imrt_pkg::op_type op, logic [6:0] addr, logic [3:0] ch,
                          logic typed, mux_route_type res);
      stim_row_type row;
      row.op    = op;
      row.addr  = addr;
      row.ch    = ch;
      row.typed = typed;
      row.res   = res;
      rows.push_back(row);
   endtask

   // Offers one item, possibly after a gap, and records its expected response on acceptance.
   task automatic send_request(imrt_pkg::op_type op, logic [6:0] addr, logic [3:0] ch,
                               logic typed, mux_route_type res);
      mux_route_type predicted;
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         req_tuser  <= 2'($urandom);
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, ch, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_route(op, addr, ch);
      pending_routes.push_back(typed ? res : predicted);
      op_hist[op]++;
   endtask

   // Stops offering items and waits until every response is back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
   endtask

   // The register is only written once the block has gone idle.
   task automatic write_mux_address(logic [6:0] value);
      drain_responses();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      chip_addr = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Response side: check each accepted item, then pick the next ready value.
   always @(posedge clock) begin : rsp_side
      mux_route_type want;
      int            hold_left;
      int            stall_served;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_routes.size() == 0) begin
            $display("%0t: response %h arrived with nothing outstanding", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_routes.pop_front();
            compare_field("status", want.status, rsp_tdata[0]);
            compare_field("found_channel", want.found, rsp_tdata[3:1]);
            compare_field("mux_write", want.mux_write, rsp_tdata[4]);
            compare_field("mux_address_byte", want.addr_byte, rsp_tdata[12:5]);
            compare_field("select_byte", want.sel_byte, rsp_tdata[20:13]);
            compare_field("tdata padding", 0, rsp_tdata[23:21]);
            checked_count++;
            if (rsp_tdata[4]) write_count++;
         end
      end
      if (stall_requests != stall_served) begin
         stall_served = stall_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus.
   initial begin : stimulus
      imrt_pkg::op_type op;
      logic [6:0]       addr;
      logic [3:0]       ch;
      logic [6:0]       addr_pool [8];
      int               roll;
      int               idx;
      int               p;
      int               i;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      for (i = 0; i < imrt_pkg::TABLE_DEPTH; i++) route_slots[i] = EMPTY_SLOT;
      for (i = 0; i < 4; i++) op_hist[i] = 0;
      cur_channel = '0;
      cur_valid   = 1'b0;
      chip_addr   = imrt_pkg::MUX_ADDR_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; the mux chip address is still at its reset value (byte 0xE0).
      add_row(imrt_pkg::OP_ACCESS, 7'h00, 4'd0,  1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_ACCESS, 7'h7F, 4'd15, 1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_SELECT, 7'h00, 4'd8,  1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_SELECT, 7'h7F, 4'd15, 1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_ADD,    7'h10, 4'd8,  1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_ADD,    7'h7F, 4'd15, 1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_NONE,   7'h55, 4'd3,  1'b1, {1'b1, 20'd0});
      // First select ever must write the mux; the repeat must not.
      add_row(imrt_pkg::OP_SELECT, 7'h00, 4'd0,  1'b1, {1'b0, 3'd0, 1'b1, 8'hE0, 8'h01});
      add_row(imrt_pkg::OP_SELECT, 7'h00, 4'd0,  1'b1, {1'b0, 3'd0, 1'b0, 8'h00, 8'h00});
      add_row(imrt_pkg::OP_ADD,    7'h00, 4'd0,  1'b1, {1'b0, 3'd0, 1'b0, 8'h00, 8'h00});
      add_row(imrt_pkg::OP_ADD,    7'h7F, 4'd7,  1'b1, {1'b0, 3'd7, 1'b0, 8'h00, 8'h00});
      add_row(imrt_pkg::OP_ACCESS, 7'h7F, 4'd0,  1'b1, {1'b0, 3'd7, 1'b1, 8'hE0, 8'h80});
      add_row(imrt_pkg::OP_ACCESS, 7'h00, 4'd15, 1'b1, {1'b0, 3'd0, 1'b1, 8'hE0, 8'h01});
      // Duplicate adds fill channel 3, then one more is rejected.
      for (i = 0; i < imrt_pkg::SLOTS_PER_CHANNEL; i++) begin
         add_row(imrt_pkg::OP_ADD, 7'h22, 4'd3, 1'b0, '0);
      end
      add_row(imrt_pkg::OP_ADD,    7'h22, 4'd3,  1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_ADD,    7'h22, 4'd1,  1'b1, {1'b0, 3'd1, 1'b0, 8'h00, 8'h00});
      add_row(imrt_pkg::OP_ACCESS, 7'h22, 4'd0,  1'b1, {1'b0, 3'd1, 1'b1, 8'hE0, 8'h02});
      add_row(imrt_pkg::OP_ACCESS, 7'h33, 4'd0,  1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_SELECT, 7'h00, 4'd1,  1'b1, {1'b0, 3'd1, 1'b0, 8'h00, 8'h00});
      add_row(imrt_pkg::OP_NONE,   7'h7F, 4'd15, 1'b1, {1'b1, 20'd0});
      add_row(imrt_pkg::OP_SELECT, 7'h00, 4'd7,  1'b1, {1'b0, 3'd7, 1'b1, 8'hE0, 8'h80});
      add_row(imrt_pkg::OP_ADD,    7'h7F, 4'd0,  1'b0, '0);
      add_row(imrt_pkg::OP_ACCESS, 7'h7F, 4'd0,  1'b0, '0);
      foreach (rows[k]) send_request(rows[k].op, rows[k].addr, rows[k].ch, rows[k].typed,
                                     rows[k].res);

      for (i = 0; i < 8; i++) addr_pool[i] = 7'($urandom_range(127));

      // Random traffic in three idle patterns, each with its own mux chip address.
      for (p = 0; p < 3; p++) begin
         case (p)
            0: write_mux_address(7'h00);
            1: write_mux_address(7'h7F);
            default: write_mux_address(7'($urandom_range(127)));
         endcase
         req_idle_pct = (p == 0) ? 12 : (p == 1) ? 67 : 0;
         rsp_idle_pct = (p == 0) ? 67 : (p == 1) ? 12 : 0;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            roll = $urandom_range(99);
            ch   = 4'($urandom_range(15));
            addr = 7'($urandom_range(127));
            if (roll < 20) begin
               op = imrt_pkg::OP_ADD;
               if ($urandom_range(99) < 85) begin
                  ch = 4'($urandom_range(imrt_pkg::CHANNEL_COUNT - 1));
               end
               if ($urandom_range(1)) addr = addr_pool[$urandom_range(7)];
            end else if (roll < 65) begin
               // Mostly look up an address that is in the table.
               op  = imrt_pkg::OP_ACCESS;
               idx = $urandom_range(imrt_pkg::TABLE_DEPTH - 1);
               if (route_slots[idx] != EMPTY_SLOT && $urandom_range(99) < 75)
                  addr = route_slots[idx][6:0];
            end else if (roll < 95) begin
               op = imrt_pkg::OP_SELECT;
               if ($urandom_range(99) < 85) begin
                  ch = 4'($urandom_range(imrt_pkg::CHANNEL_COUNT - 1));
               end
            end else begin
               op = imrt_pkg::OP_NONE;
            end
            send_request(op, addr, ch, 1'b0, '0);
            // Long receiver hold-off while items keep coming.
            if (p == 0 && i == 80) stall_requests++;
            // Sender waits for the pipeline to empty, then carries on.
            if (p == 1 && i == 120) drain_responses();
            if (p == 2 && i == 125) write_mux_address(7'($urandom_range(127)));
         end
      end

      drain_responses();
      repeat (40) @(posedge clock);
      $display("Requests: %0d add, %0d lookup, %0d select, %0d undefined; %0d responses checked.",
               op_hist[imrt_pkg::OP_ADD], op_hist[imrt_pkg::OP_ACCESS],
               op_hist[imrt_pkg::OP_SELECT], op_hist[imrt_pkg::OP_NONE], checked_count);
      $display("Mux writes seen: %0d, under five chip address settings, with stalls on both sides.",
               write_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
